FILE: hdl/titm_pkg.sv
// Shared types and codes of the time interval target map.
`default_nettype none
package titm_pkg;
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHL,
      CELL_SHR
   } cell_mode_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_REVERSED = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [8:0] TGT_NONE   = 9'h1FF;
   localparam logic       CMD_PAINT  = 1'b0;
   localparam logic       CMD_LOOKUP = 1'b1;
endpackage
`default_nettype wire

FILE: hdl/time_interval_target_map_top.sv
// Top level of the time interval target map: cell row and sequencer.
// Keeps a sorted row of time boundaries, each carrying the target that holds
// from its time up to the next boundary; no-target (-1) outside the row.
// Input channel req_*: command 0 paints target over [start_time, stop_time),
// command 1 looks up the target at query_time. Result channel rsp_*: one item
// per input item with found_target, status and boundary_count.
// A lookup registers every cell's compare against the keys loaded at
// acceptance, then selects the cell. A paint compares and evaluates, shifts
// the row left one cell per cycle to remove the D boundaries it covers, then
// runs the two insert steps. A paint that would overflow answers after the
// evaluate step; empty and reversed paints answer on acceptance. One item is
// in work at a time; the next can be taken the cycle after the result is
// accepted.
// Reset empties the table at once (no clearing pass) and drops any result.
// When the receiver stalls, the result is held and no new item is taken.
`default_nettype none
module time_interval_target_map_top import titm_pkg::*; #(
   parameter int MAX_BOUNDARIES = 64,
   parameter int TARGET_COUNT   = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_command,
   input  wire logic [63:0] req_start_time,
   input  wire logic [63:0] req_stop_time,
   input  wire logic [8:0]  req_target,
   input  wire logic [63:0] req_query_time,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [8:0]       rsp_found_target,
   output logic [1:0]       rsp_status,
   output logic [6:0]       rsp_boundary_count
);
   localparam int CW = $clog2(MAX_BOUNDARIES + 1);
   localparam int N  = MAX_BOUNDARIES;

   typedef enum logic [2:0] {
      S_IDLE, S_CMP, S_EVAL, S_DEL, S_INS_S, S_INS_E
   } state_type;

   state_type     state_ff;
   logic          cmd_ff;
   logic [63:0]   start_ff, stop_ff;
   logic [8:0]    tgt_ff, stopval_ff;
   logic [CW-1:0] n_ff, a_ff, del_ff;
   logic          ins_s_ff, ins_e_ff;
   logic          rsp_valid_ff;
   logic [8:0]    rsp_found_ff;
   logic [1:0]    rsp_status_ff;
   logic [6:0]    rsp_count_ff;

   cell_mode_type mode;
   logic [CW-1:0] pos;
   logic [63:0]   ld_time;
   logic [8:0]    ld_target;

   logic [63:0] c_time [N];
   logic [8:0]  c_tgt  [N];
   logic [N-1:0] lt_v, le_v;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         logic lt_raw, le_raw;
         titm_cell #(.CW(CW), .IDX(g)) u_cell (
            .clock(clock), .mode(mode), .pos(pos),
            .ld_time(ld_time), .ld_target(ld_target),
            .l_time(c_time[(g == 0) ? 0 : g - 1]),
            .l_target(c_tgt[(g == 0) ? 0 : g - 1]),
            .r_time(c_time[(g == N - 1) ? g : g + 1]),
            .r_target(c_tgt[(g == N - 1) ? g : g + 1]),
            .start_key(start_ff), .stop_key(stop_ff),
            .cell_time(c_time[g]), .cell_target(c_tgt[g]),
            .lt_start(lt_raw), .le_stop(le_raw)
         );
         assign lt_v[g] = lt_raw && (CW'(g) < n_ff);
         assign le_v[g] = le_raw && (CW'(g) < n_ff);
      end
   endgenerate

   logic [CW-1:0] a_c, b_c;
   logic [8:0]    before_c, stopval_c;
   logic          ins_s_c, ins_e_c;
   logic [CW:0]   m_c;
   logic          next_lt, next_le;

   always_comb begin
      a_c = '0;
      b_c = '0;
      before_c = '0;
      stopval_c = '0;
      for (int i = 0; i < N; i++) begin
         next_lt = (i == N - 1) ? 1'b0 : lt_v[(i == N - 1) ? i : i + 1];
         next_le = (i == N - 1) ? 1'b0 : le_v[(i == N - 1) ? i : i + 1];
         if (lt_v[i] && !next_lt) begin
            a_c = a_c | CW'(i + 1);
            before_c = before_c | c_tgt[i];
         end
         if (le_v[i] && !next_le) begin
            b_c = b_c | CW'(i + 1);
            stopval_c = stopval_c | c_tgt[i];
         end
      end
      if (a_c == '0) before_c = TGT_NONE;
      if (b_c == '0) stopval_c = TGT_NONE;
      ins_s_c = tgt_ff != before_c;
      ins_e_c = stopval_c != tgt_ff;
      m_c = {1'b0, n_ff} - {1'b0, b_c} + {1'b0, a_c}
            + (CW + 1)'(ins_s_c) + (CW + 1)'(ins_e_c);
   end

   logic [8:0]  paint_tgt;
   logic [31:0] tgt_wide;
   assign tgt_wide  = {24'd0, req_target[7:0]};
   assign paint_tgt = (!req_target[8] && (tgt_wide < 32'(TARGET_COUNT)))
                      ? req_target : TGT_NONE;

   always_comb begin
      mode      = CELL_HOLD;
      pos       = a_ff;
      ld_time   = start_ff;
      ld_target = tgt_ff;
      case (state_ff)
         S_DEL: if (del_ff != '0) mode = CELL_SHL;
         S_INS_S: if (ins_s_ff) mode = CELL_SHR;
         S_INS_E: begin
            if (ins_e_ff) mode = CELL_SHR;
            pos       = a_ff + CW'(ins_s_ff);
            ld_time   = stop_ff;
            ld_target = stopval_ff;
         end
         default: begin
         end
      endcase
   end

   function automatic logic [6:0] cnt7(input logic [CW-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return w[6:0];
   endfunction

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  cmd_ff   <= req_command;
                  start_ff <= req_start_time;
                  stop_ff  <= (req_command == CMD_PAINT) ? req_stop_time : req_query_time;
                  tgt_ff   <= paint_tgt;
                  rsp_found_ff <= TGT_NONE;
                  rsp_count_ff <= cnt7(n_ff);
                  if (req_command != CMD_PAINT) begin
                     state_ff <= S_CMP;
                  end else if (req_start_time == req_stop_time) begin
                     rsp_status_ff <= ST_EMPTY;
                     rsp_valid_ff  <= 1'b1;
                  end else if ($signed(req_start_time) > $signed(req_stop_time)) begin
                     rsp_status_ff <= ST_REVERSED;
                     rsp_valid_ff  <= 1'b1;
                  end else begin
                     state_ff <= S_CMP;
                  end
               end
            end
            S_CMP: state_ff <= S_EVAL;
            S_EVAL: begin
               if (cmd_ff != CMD_PAINT) begin
                  rsp_found_ff  <= stopval_c;
                  rsp_status_ff <= ST_OK;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else if (m_c > (CW + 1)'(MAX_BOUNDARIES)) begin
                  rsp_status_ff <= ST_FULL;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  a_ff       <= a_c;
                  del_ff     <= b_c - a_c;
                  ins_s_ff   <= ins_s_c;
                  ins_e_ff   <= ins_e_c;
                  stopval_ff <= stopval_c;
                  state_ff   <= S_DEL;
               end
            end
            S_DEL: begin
               if (del_ff != '0) begin
                  del_ff <= del_ff - CW'(1);
                  n_ff   <= n_ff - CW'(1);
               end else begin
                  state_ff <= S_INS_S;
               end
            end
            S_INS_S: begin
               n_ff     <= n_ff + CW'(ins_s_ff);
               state_ff <= S_INS_E;
            end
            S_INS_E: begin
               n_ff          <= n_ff + CW'(ins_e_ff);
               rsp_count_ff  <= cnt7(n_ff + CW'(ins_e_ff));
               rsp_status_ff <= ST_OK;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found_target   = rsp_found_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_boundary_count = rsp_count_ff;
endmodule
`default_nettype wire

FILE: hdl/titm_cell.sv
// One boundary cell: holds a time and its target, shifts with its neighbours.
`default_nettype none
module titm_cell import titm_pkg::*; #(
   parameter int CW  = 7,
   parameter int IDX = 0
) (
   input  wire logic              clock,
   input  wire cell_mode_type     mode,
   input  wire logic [CW-1:0]     pos,
   input  wire logic [63:0]       ld_time,
   input  wire logic [8:0]        ld_target,
   input  wire logic [63:0]       l_time,
   input  wire logic [8:0]        l_target,
   input  wire logic [63:0]       r_time,
   input  wire logic [8:0]        r_target,
   input  wire logic [63:0]       start_key,
   input  wire logic [63:0]       stop_key,
   output logic      [63:0]       cell_time,
   output logic      [8:0]        cell_target,
   output logic                   lt_start,
   output logic                   le_stop
);
   logic [63:0] time_ff, time_in;
   logic [8:0]  tgt_ff, tgt_in;
   logic        lt_ff, le_ff;
   logic [CW-1:0] my_idx;

   assign my_idx = CW'(IDX);

   always_comb begin
      time_in = time_ff;
      tgt_in  = tgt_ff;
      case (mode)
         CELL_SHL: begin
            if (my_idx >= pos) begin
               time_in = r_time;
               tgt_in  = r_target;
            end
         end
         CELL_SHR: begin
            if (my_idx == pos) begin
               time_in = ld_time;
               tgt_in  = ld_target;
            end else if (my_idx > pos) begin
               time_in = l_time;
               tgt_in  = l_target;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      tgt_ff  <= tgt_in;
      lt_ff   <= $signed(time_ff) < $signed(start_key);
      le_ff   <= $signed(time_ff) <= $signed(stop_key);
   end

   assign cell_time   = time_ff;
   assign cell_target = tgt_ff;
   assign lt_start    = lt_ff;
   assign le_stop     = le_ff;
endmodule
`default_nettype wire
